[rtl/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Signal must hold no more than one set bit.
`define ASSERT_ONEHOT0(label, clk, rst, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) $onehot0(sig)) else $error(msg);

`endif

[rtl/mlpf_pkg.sv]
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared types and fixed-point constants of the MLP forward-inference block.
// ----------------------------------------------------------------------------
package mlpf_pkg;

   localparam int FEATURE_WIDTH = 16;
   localparam int VALUE_WIDTH   = 24;
   localparam int ACC_WIDTH     = 48;
   localparam int FRAC_BITS     = 12;
   localparam int MAX_INPUTS    = 5;
   localparam int INDEX_WIDTH   = 7;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 24'sh7FFFFF;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 24'sh800000;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_INFER = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MAC,
      ST_STORE,
      ST_EMIT
   } state_type;

   // Control sent from the sequencer to the lane array.
   typedef struct packed {
      logic clear;
      logic mac;
   } lane_ctrl_type;

   // Floor shift by the fraction bits, then saturate to the value range.
   function automatic logic signed [VALUE_WIDTH-1:0] rescale(
      input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [ACC_WIDTH-FRAC_BITS-1:0] s;
      s = acc[ACC_WIDTH-1:FRAC_BITS];
      if (s > 36'sd8388607) begin
         return VALUE_MAX;
      end else if (s < -36'sd8388608) begin
         return VALUE_MIN;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

endpackage

[rtl/mlp_forward_inference_top.sv]
// A weight write goes into the RAM on accept. An inference walks each layer as
// fan_in passes of fan_out FETCH states and a MAC state, then a STORE state;
// an EMIT state then gives one result beat per output neuron.
// Input is held off until the last result beat is taken, so a new inference is not
// accepted before the last one is through. The single RAM read port sets the pace.
// Reset: synchronous, active high; clears control state, the RAM is not cleared.
// ----------------------------------------------------------------------------
// mlp_forward_inference_top
// Feed-forward network with one MAC lane per neuron of the widest layer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlp_forward_inference_top #(
   parameter int INPUT_COUNT         = 5,
   parameter int FIRST_HIDDEN_COUNT  = 8,
   parameter int SECOND_HIDDEN_COUNT = 7,
   parameter int OUTPUT_COUNT        = 2,
   parameter int WEIGHT_WIDTH        = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [6:0]  req_weight_index,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_feature_0,
   input  logic signed [15:0] req_feature_1,
   input  logic signed [15:0] req_feature_2,
   input  logic signed [15:0] req_feature_3,
   input  logic signed [15:0] req_feature_4,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [23:0] rsp_output_value,
   output logic        rsp_output_index,
   output logic        rsp_last_output
);

   localparam int VW = mlpf_pkg::VALUE_WIDTH;
   localparam int L1 = INPUT_COUNT * FIRST_HIDDEN_COUNT;
   localparam int L2 = FIRST_HIDDEN_COUNT * SECOND_HIDDEN_COUNT;
   localparam int L3 = SECOND_HIDDEN_COUNT * OUTPUT_COUNT;
   localparam int TOTAL = L1 + L2 + L3;
   localparam int LANES0 = (FIRST_HIDDEN_COUNT > SECOND_HIDDEN_COUNT) ?
                           FIRST_HIDDEN_COUNT : SECOND_HIDDEN_COUNT;
   localparam int LANES = (LANES0 > OUTPUT_COUNT) ? LANES0 : OUTPUT_COUNT;
   localparam int AW = $clog2(TOTAL);
   localparam int MAXIN0 = (INPUT_COUNT > FIRST_HIDDEN_COUNT) ?
                           INPUT_COUNT : FIRST_HIDDEN_COUNT;
   localparam int MAXIN = (MAXIN0 > SECOND_HIDDEN_COUNT) ? MAXIN0 : SECOND_HIDDEN_COUNT;
   localparam int JW = $clog2(MAXIN + 1);
   localparam int NW = $clog2(LANES + 1);
   localparam int OW = $clog2(OUTPUT_COUNT + 1);
   localparam int VIW = $clog2(MAXIN);
   localparam int LIW = $clog2(LANES);

   // Sequencer registers.
   mlpf_pkg::state_type state_ff, state_in;
   logic [1:0]    layer_ff, layer_in;
   logic [NW-1:0] neuron_ff, neuron_in;
   logic [JW-1:0] step_ff, step_in;
   logic [OW-1:0] out_ff, out_in;
   logic          wt_valid_ff;

   // Value registers: features, then each layer's results.
   logic signed [VW-1:0] vals_ff [MAXIN];
   logic signed [VW-1:0] lane_res [LANES];
   logic signed [WEIGHT_WIDTH-1:0] wts_ff [LANES];
   logic signed [15:0]   feat [5];

   // Weight RAM.
   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [WEIGHT_WIDTH-1:0] wr_data, rd_data;
   logic signed [15:0]      wsrc;

   logic [JW-1:0] fan_in;
   logic [NW-1:0] fan_out;
   int            base;
   mlpf_pkg::lane_ctrl_type ctrl;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_value_ff;
   logic                 rsp_last_ff;
   logic [OW-1:0]        rsp_idx_ff;

   // Layer geometry.
   always_comb begin
      unique case (layer_ff)
         2'd0: begin
            fan_in = JW'(INPUT_COUNT); fan_out = NW'(FIRST_HIDDEN_COUNT); base = 0;
         end
         2'd1: begin
            fan_in = JW'(FIRST_HIDDEN_COUNT); fan_out = NW'(SECOND_HIDDEN_COUNT);
            base = L1;
         end
         default: begin
            fan_in = JW'(SECOND_HIDDEN_COUNT); fan_out = NW'(OUTPUT_COUNT);
            base = L1 + L2;
         end
      endcase
   end

   assign wsrc    = req_weight_value;
   assign wr_data = WEIGHT_WIDTH'(wsrc);
   assign wr_addr = AW'(req_weight_index);
   assign wr_en   = req_valid && req_ready && req_mode == mlpf_pkg::MODE_WRITE &&
                    {1'b0, req_weight_index} < 8'(TOTAL);
   assign rd_addr = AW'(base + int'(neuron_ff) * int'(fan_in) + int'(step_ff));

   mlpf_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(TOTAL)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == mlpf_pkg::ST_IDLE) && !rsp_valid_ff;

   // Sequencer: FETCH walks the layer's neurons at the current step; each read lands
   // in that neuron's weight register. MAC then accumulates that column, fan_in times.
   always_comb begin
      state_in = state_ff; layer_in = layer_ff; neuron_in = neuron_ff;
      step_in = step_ff; out_in = out_ff; ctrl = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         mlpf_pkg::ST_IDLE: begin
            if (req_valid && req_ready && req_mode == mlpf_pkg::MODE_INFER) begin
               state_in = mlpf_pkg::ST_FETCH; layer_in = 2'd0;
               neuron_in = '0; step_in = '0;
            end
         end
         mlpf_pkg::ST_FETCH: begin
            // One neuron per pass; the step index selects the weight column.
            if (neuron_ff == fan_out - NW'(1)) begin
               neuron_in = '0;
               state_in  = mlpf_pkg::ST_MAC;
               if (step_ff == '0) ctrl.clear = 1'b1;
            end else begin
               neuron_in = neuron_ff + NW'(1);
            end
         end
         mlpf_pkg::ST_MAC: begin
            // Accumulate one column; the lane of the layer's last neuron takes its weight from the RAM.
            ctrl.mac = 1'b1;
            if (step_ff == fan_in - JW'(1)) begin
               step_in = '0; state_in = mlpf_pkg::ST_STORE;
            end else begin
               step_in = step_ff + JW'(1); state_in = mlpf_pkg::ST_FETCH;
            end
         end
         mlpf_pkg::ST_STORE: begin
            if (layer_ff == 2'd2) begin
               state_in = mlpf_pkg::ST_EMIT; out_in = '0;
            end else begin
               layer_in = layer_ff + 2'd1; state_in = mlpf_pkg::ST_FETCH;
            end
         end
         mlpf_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (out_ff == OW'(OUTPUT_COUNT - 1)) state_in = mlpf_pkg::ST_IDLE;
               else out_in = out_ff + OW'(1);
            end
         end
         default: state_in = mlpf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlpf_pkg::ST_IDLE; layer_ff <= '0; neuron_ff <= '0;
         step_ff <= '0; out_ff <= '0; rsp_valid_ff <= 1'b0; wt_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; layer_ff <= layer_in; neuron_ff <= neuron_in;
         step_ff <= step_in; out_ff <= out_in; rsp_valid_ff <= rsp_valid_in;
         wt_valid_ff <= (state_ff == mlpf_pkg::ST_FETCH);
      end
   end

   // RAM data arrives in the cycle after its address; park it in the lane's slot.
   logic [NW-1:0] wt_lane_ff;
   always_ff @(posedge clock) begin
      wt_lane_ff <= neuron_ff;
      if (wt_valid_ff) begin
         for (int k = 0; k < LANES; k++) begin
            if (wt_lane_ff == NW'(k)) wts_ff[k] <= rd_data;
         end
      end
   end

   assign feat[0] = req_feature_0;
   assign feat[1] = req_feature_1;
   assign feat[2] = req_feature_2;
   assign feat[3] = req_feature_3;
   assign feat[4] = req_feature_4;

   // Feature load on accept; layer results written back at STORE.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_mode == mlpf_pkg::MODE_INFER) begin
         for (int k = 0; k < MAXIN; k++) begin
            vals_ff[k] <= (k < INPUT_COUNT) ? VW'(feat[k % 5]) : '0;
         end
      end else if (state_ff == mlpf_pkg::ST_STORE && layer_ff != 2'd2) begin
         for (int k = 0; k < MAXIN; k++) begin
            vals_ff[k] <= (k < LANES) ? lane_res[k % LANES] : '0;
         end
      end
   end

   // Lanes: every lane multiplies the shared operand by its own weight.
   logic signed [VW-1:0] operand;
   assign operand = vals_ff[VIW'(step_ff)];

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      mlpf_lane #(.WEIGHT_WIDTH(WEIGHT_WIDTH)) u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .operand(operand),
         .weight ((wt_valid_ff && wt_lane_ff == NW'(g)) ? $signed(rd_data) : wts_ff[g]),
         .result (lane_res[g])
      );
   end

   // Merge stage: pick the output lane for each result beat.
   always_ff @(posedge clock) begin
      if (state_ff == mlpf_pkg::ST_EMIT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_value_ff <= lane_res[LIW'(out_ff)];
         rsp_idx_ff   <= out_ff;
         rsp_last_ff  <= (out_ff == OW'(OUTPUT_COUNT - 1));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_value = rsp_value_ff;
   assign rsp_output_index = rsp_idx_ff[0];
   assign rsp_last_output  = rsp_last_ff;

   `ASSERT_CLK(a_no_accept_busy, clock, reset,
      (state_ff != mlpf_pkg::ST_IDLE) |-> !req_ready, "accept while busy")
   `ASSERT_CLK(a_emit_from_idle, clock, reset,
      $rose(rsp_valid) |-> $past(state_ff) == mlpf_pkg::ST_EMIT, "stray result")
   `ASSERT_ONEHOT0(a_ctrl, clock, reset, ctrl, "clear and mac together")

endmodule

[rtl/mlpf_ram.sv]
// ----------------------------------------------------------------------------
// mlpf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mlpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 110
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mlpf_lane.sv]
// ----------------------------------------------------------------------------
// mlpf_lane
// One multiply-accumulate lane: a combinational product feeds a registered 48-bit sum.
// ----------------------------------------------------------------------------
module mlpf_lane #(
   parameter int WEIGHT_WIDTH = 16
) (
   input  logic                                    clock,
   input  mlpf_pkg::lane_ctrl_type                 ctrl,
   input  logic signed [mlpf_pkg::VALUE_WIDTH-1:0] operand,
   input  logic signed [WEIGHT_WIDTH-1:0]          weight,
   output logic signed [mlpf_pkg::VALUE_WIDTH-1:0] result
);

   localparam int PROD_WIDTH = mlpf_pkg::VALUE_WIDTH + WEIGHT_WIDTH;

   logic signed [mlpf_pkg::ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [PROD_WIDTH-1:0]          prod;

   // Product is exact; the sum wraps at the accumulator width.
   always_comb begin
      prod   = PROD_WIDTH'(operand) * PROD_WIDTH'(weight);
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.mac) begin
         acc_in = acc_ff + mlpf_pkg::ACC_WIDTH'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign result = mlpf_pkg::rescale(acc_ff);

endmodule
